// ===== rtl/core/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package lr_pkg;

    // Default pixel coordinate width
    localparam int COORD_BITS_DEF = 11;

    // Endpoint fields on the input stream are 12-bit two's complement
    localparam int IN_COORD_BITS = 12;

    // Colour: one byte per component, four components
    localparam int COMP_BITS   = 8;
    localparam int COLOUR_BITS = 4 * COMP_BITS;

    // Input stream payload: four endpoint coordinates and the colour
    localparam int IN_TDATA_BITS = 4 * IN_COORD_BITS + COLOUR_BITS;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0]  WIDTH_RESET    = 12'd640;
    localparam logic [CFG_DATA_BITS-1:0]  HEIGHT_RESET   = 12'd480;

    // Command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Classified operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_START,
        OP_REJECT,
        OP_STEP
    } t_op;

    localparam int OP_BITS = 2;

    // Stepping direction flags of a loaded line
    typedef struct packed {
        logic y_dec;
        logic x_dec;
        logic x_major;
    } t_step_flags;

    localparam int FLAG_BITS = 3;

endpackage

// ===== rtl/core/lr_front.sv =====
// Front end: screen size registers, endpoint checks and line setup.
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_write,
    input  logic [lr_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [lr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                i_command,
    input  logic [lr_pkg::IN_TDATA_BITS-1:0]    i_data,
    output logic [6*COORD_BITS+lr_pkg::OP_BITS+lr_pkg::FLAG_BITS+lr_pkg::COLOUR_BITS-1:0] o_entry
);

    localparam int CW  = COORD_BITS;
    localparam int ICB = lr_pkg::IN_COORD_BITS;
    localparam logic [16:0] CoordMax = 17'((1 << COORD_BITS) - 1);

    logic [lr_pkg::CFG_DATA_BITS-1:0] r_active_width;
    logic [lr_pkg::CFG_DATA_BITS-1:0] r_active_height;

    logic [ICB-1:0]  sx_in, sy_in, ex_in, ey_in;
    logic [CW-1:0]   sx, sy, ex, ey;
    logic [CW-1:0]   dx, dy, d_major, d_minor;
    logic            all_ok;
    lr_pkg::t_step_flags flags;
    lr_pkg::t_op     op;
    logic [lr_pkg::COLOUR_BITS-1:0] colour;

    function automatic logic coord_ok(input logic [ICB-1:0] v,
                                      input logic [lr_pkg::CFG_DATA_BITS-1:0] limit);
        logic neg;
        logic in_screen;
        logic fits;
        neg       = v[ICB-1];
        in_screen = lr_pkg::CFG_DATA_BITS'(v[ICB-2:0]) < limit;
        fits      = 17'(v[ICB-2:0]) <= CoordMax;
        return !neg && in_screen && fits;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= lr_pkg::WIDTH_RESET;
            r_active_height <= lr_pkg::HEIGHT_RESET;
        end else if (i_cfg_write) begin
            if (i_cfg_index == lr_pkg::CFG_IDX_WIDTH) begin
                r_active_width <= i_cfg_data;
            end
            if (i_cfg_index == lr_pkg::CFG_IDX_HEIGHT) begin
                r_active_height <= i_cfg_data;
            end
        end
    end

    assign sx_in = i_data[0*ICB +: ICB];
    assign sy_in = i_data[1*ICB +: ICB];
    assign ex_in = i_data[2*ICB +: ICB];
    assign ey_in = i_data[3*ICB +: ICB];

    assign all_ok = coord_ok(sx_in, r_active_width)  && coord_ok(ex_in, r_active_width) &&
                    coord_ok(sy_in, r_active_height) && coord_ok(ey_in, r_active_height);

    // Only meaningful once all_ok holds; then every value fits CW bits
    assign sx = CW'(sx_in[ICB-2:0]);
    assign sy = CW'(sy_in[ICB-2:0]);
    assign ex = CW'(ex_in[ICB-2:0]);
    assign ey = CW'(ey_in[ICB-2:0]);

    always_comb begin
        flags.x_dec   = ex < sx;
        flags.y_dec   = ey < sy;
        dx            = flags.x_dec ? (sx - ex) : (ex - sx);
        dy            = flags.y_dec ? (sy - ey) : (ey - sy);
        flags.x_major = dx >= dy;
        d_major       = flags.x_major ? dx : dy;
        d_minor       = flags.x_major ? dy : dx;
    end

    always_comb begin
        if (i_command == lr_pkg::CMD_STEP) begin
            op = lr_pkg::OP_STEP;
        end else if (all_ok) begin
            op = lr_pkg::OP_START;
        end else begin
            op = lr_pkg::OP_REJECT;
        end
    end

    // Red in the high byte, alpha in the low byte
    assign colour = {i_data[4*ICB +: 8], i_data[4*ICB+8 +: 8],
                     i_data[4*ICB+16 +: 8], i_data[4*ICB+24 +: 8]};

    assign o_entry = {colour, flags, op, d_minor, d_major, ey, ex, sy, sx};

endmodule

// ===== rtl/core/lr_queue.sv =====
// Two-entry queue between the front end and the stepping engine.
module lr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> !i_pop)
        else $error("pop while queue empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !i_push)
        else $error("push while queue full");
`endif

endmodule

// ===== rtl/core/lr_back.sv =====
// Stepping engine: holds the line in progress and drives the result register.
module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  logic [6*COORD_BITS+lr_pkg::OP_BITS+lr_pkg::FLAG_BITS+lr_pkg::COLOUR_BITS-1:0] i_q_data,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [lr_pkg::COLOUR_BITS-1:0]     o_colour,
    output logic                               o_last_pixel,
    output logic                               o_rejected
);

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    // Queue entry fields
    logic [CW-1:0]                  q_sx, q_sy, q_tx, q_ty, q_dmaj, q_dmin;
    lr_pkg::t_op                    q_op;
    lr_pkg::t_step_flags            q_flags;
    logic [lr_pkg::COLOUR_BITS-1:0] q_colour;

    // Line state
    logic                           r_active, n_active;
    logic [CW-1:0]                  r_cx, n_cx, r_cy, n_cy;
    logic [CW-1:0]                  r_tx, n_tx, r_ty, n_ty;
    logic [CW-1:0]                  r_dmaj, n_dmaj, r_dmin, n_dmin;
    logic signed [EW-1:0]           r_err, n_err;
    lr_pkg::t_step_flags            r_flags, n_flags;
    logic [lr_pkg::COLOUR_BITS-1:0] r_colour, n_colour;

    // Result register
    logic                           r_out_valid, n_out_valid;
    logic [CW-1:0]                  r_px, n_px, r_py, n_py;
    logic [lr_pkg::COLOUR_BITS-1:0] r_out_colour, n_out_colour;
    logic                           r_out_last, n_out_last;
    logic                           r_out_rej, n_out_rej;

    logic                           pop, last, move_minor, x_move, y_move;
    logic signed [EW-1:0]           err_sum, err_wrap;
    logic [CW-1:0]                  step_x, step_y;

    assign q_sx     = i_q_data[0*CW +: CW];
    assign q_sy     = i_q_data[1*CW +: CW];
    assign q_tx     = i_q_data[2*CW +: CW];
    assign q_ty     = i_q_data[3*CW +: CW];
    assign q_dmaj   = i_q_data[4*CW +: CW];
    assign q_dmin   = i_q_data[5*CW +: CW];
    assign q_op     = lr_pkg::t_op'(i_q_data[6*CW +: lr_pkg::OP_BITS]);
    assign q_flags  = lr_pkg::t_step_flags'(
                          i_q_data[6*CW+lr_pkg::OP_BITS +: lr_pkg::FLAG_BITS]);
    assign q_colour = i_q_data[6*CW+lr_pkg::OP_BITS+lr_pkg::FLAG_BITS +: lr_pkg::COLOUR_BITS];

    // Take the next request whenever the result register is free or draining
    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;

    assign last = r_flags.x_major ? (r_cx == r_tx) : (r_cy == r_ty);

    // Error is scaled by twice the major delta: one half is the major delta
    assign err_sum    = r_err + $signed({2'b00, r_dmin, 1'b0});
    assign err_wrap   = err_sum - $signed({2'b00, r_dmaj, 1'b0});
    assign move_minor = err_sum > $signed({3'b000, r_dmaj});
    assign x_move     = r_flags.x_major || move_minor;
    assign y_move     = !r_flags.x_major || move_minor;
    assign step_x     = r_flags.x_dec ? (r_cx - CW'(1)) : (r_cx + CW'(1));
    assign step_y     = r_flags.y_dec ? (r_cy - CW'(1)) : (r_cy + CW'(1));

    always_comb begin
        n_active     = r_active;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_dmaj       = r_dmaj;
        n_dmin       = r_dmin;
        n_err        = r_err;
        n_flags      = r_flags;
        n_colour     = r_colour;
        n_out_valid  = r_out_valid && !i_ready;
        n_px         = r_px;
        n_py         = r_py;
        n_out_colour = r_out_colour;
        n_out_last   = r_out_last;
        n_out_rej    = r_out_rej;
        if (pop) begin
            unique case (q_op)
                lr_pkg::OP_START: begin
                    n_active = 1'b1;
                    n_cx     = q_sx;
                    n_cy     = q_sy;
                    n_tx     = q_tx;
                    n_ty     = q_ty;
                    n_dmaj   = q_dmaj;
                    n_dmin   = q_dmin;
                    n_err    = '0;
                    n_flags  = q_flags;
                    n_colour = q_colour;
                end
                lr_pkg::OP_REJECT: begin
                    n_active     = 1'b0;
                    n_out_valid  = 1'b1;
                    n_px         = '0;
                    n_py         = '0;
                    n_out_colour = '0;
                    n_out_last   = 1'b0;
                    n_out_rej    = 1'b1;
                end
                lr_pkg::OP_STEP: begin
                    if (r_active) begin
                        n_out_valid  = 1'b1;
                        n_px         = r_cx;
                        n_py         = r_cy;
                        n_out_colour = r_colour;
                        n_out_last   = last;
                        n_out_rej    = 1'b0;
                        if (last) begin
                            n_active = 1'b0;
                        end else begin
                            n_cx  = x_move ? step_x : r_cx;
                            n_cy  = y_move ? step_y : r_cy;
                            n_err = move_minor ? err_wrap : err_sum;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_dmaj      <= '0;
            r_dmin      <= '0;
            r_err       <= '0;
            r_flags     <= '0;
            r_colour    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_tx        <= n_tx;
            r_ty        <= n_ty;
            r_dmaj      <= n_dmaj;
            r_dmin      <= n_dmin;
            r_err       <= n_err;
            r_flags     <= n_flags;
            r_colour    <= n_colour;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_py         <= n_py;
        r_out_colour <= n_out_colour;
        r_out_last   <= n_out_last;
        r_out_rej    <= n_out_rej;
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_colour     = r_out_colour;
    assign o_last_pixel = r_out_last;
    assign o_rejected   = r_out_rej;

`ifndef NO_ASSERTIONS
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_err <= $signed({3'b000, r_dmaj})) &&
                     (r_err >= -$signed({3'b000, r_dmaj})))
        else $error("error term left its range");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rej) |-> (!r_out_last && r_px == '0 && r_py == '0))
        else $error("rejected result carries pixel data");

    a_start_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !$past(r_active)) |-> $past(pop && q_op == lr_pkg::OP_START))
        else $error("line became active without a start request");
`endif

endmodule

// ===== rtl/core/line_rasterizer.sv =====
// Line rasterizer top level: front end, request queue and stepping engine.
//
//  channel  | direction | handshake                 | payload
//  s_axis   | in        | i_s_tvalid / o_s_tready   | i_s_tdata, i_s_tuser (command)
//  m_axis   | out       | o_m_tvalid / i_m_tready   | o_m_tdata, o_m_tlast, o_m_tuser
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while the output is not stalled; each request is registered in the
// queue and its result in the result register. The front end checks endpoints and sets up
// deltas combinationally; the stepping engine does one error add and compare per pixel.
// Reset is synchronous, active low, and restores a 640 x 480 screen with no line.
// A two-entry queue and the result register absorb a stalled output.
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // start_x, start_y, end_x, end_y (12 each), red_in, green_in, blue_in, alpha_in
    input  logic [lr_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    // command
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out, alpha_out, zero fill
    output logic [((2*COORD_BITS+lr_pkg::COLOUR_BITS+7)/8)*8-1:0] o_m_tdata,
    output logic                              o_m_tlast,
    // rejected
    output logic                              o_m_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int EntryBits = 6*COORD_BITS + lr_pkg::OP_BITS + lr_pkg::FLAG_BITS +
                               lr_pkg::COLOUR_BITS;
    localparam int OutBits   = ((2*COORD_BITS + lr_pkg::COLOUR_BITS + 7) / 8) * 8;

    logic [EntryBits-1:0]           entry, q_data;
    logic                           q_ready, q_valid, q_pop, push;
    logic [COORD_BITS-1:0]          pixel_x, pixel_y;
    logic [lr_pkg::COLOUR_BITS-1:0] colour;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = q_ready;
    assign push        = i_s_tvalid && q_ready;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_s_tuser),
        .i_data      (i_s_tdata),
        .o_entry     (entry)
    );

    lr_queue #(
        .WIDTH (EntryBits)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_colour     (colour),
        .o_last_pixel (o_m_tlast),
        .o_rejected   (o_m_tuser)
    );

    // Colour holds red in its high byte; the stream wants red first
    assign o_m_tdata = OutBits'({colour[7:0], colour[15:8], colour[23:16], colour[31:24],
                                 pixel_y, pixel_x});

endmodule

// ===== tb/line_pixel_checker.sv =====
// Pixel scoreboard: predicts rasterizer results from accepted requests and compares them.
`timescale 1ns / 1ps

module line_pixel_checker #(
    parameter int CB    = lr_pkg::COORD_BITS_DEF,
    parameter int OUT_W = ((2 * CB + lr_pkg::COLOUR_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [lr_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    input  logic                              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [OUT_W-1:0]                  i_m_tdata,
    input  logic                              i_m_tlast,
    input  logic                              i_m_tuser,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [lr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                o_pending,
    output int                                o_fail_count
);

    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int CW        = lr_pkg::IN_COORD_BITS;
    localparam int KW        = lr_pkg::COMP_BITS;
    localparam int FILL_LSB  = 2 * CB + lr_pkg::COLOUR_BITS;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [KW-1:0] red;
        logic [KW-1:0] green;
        logic [KW-1:0] blue;
        logic [KW-1:0] alpha;
        logic          last;
        logic          rejected;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     fail_total = 0;

    // Predicted block state
    int                             screen_w;
    int                             screen_h;
    logic                           line_on;
    logic [CB-1:0]                  cur_x;
    logic [CB-1:0]                  cur_y;
    logic [CB-1:0]                  tgt_x;
    logic [CB-1:0]                  tgt_y;
    int                             d_major;
    int                             d_minor;
    int                             err;
    lr_pkg::t_step_flags            dir;
    logic [lr_pkg::COLOUR_BITS-1:0] rgba;

    function automatic bit on_screen(input int v, input int lim);
        return v >= 0 && v < lim && v <= COORD_MAX;
    endfunction

    function automatic int field_diff(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    task automatic rasterize(input logic cmd, input logic [lr_pkg::IN_TDATA_BITS-1:0] req);
        int     x0, y0, x1, y1, dx, dy;
        pixel_t px;
        logic   at_end;
        x0 = $signed(req[0 * CW +: CW]);
        y0 = $signed(req[1 * CW +: CW]);
        x1 = $signed(req[2 * CW +: CW]);
        y1 = $signed(req[3 * CW +: CW]);
        px = '0;
        if (cmd == lr_pkg::CMD_START) begin
            line_on = 1'b0;
            if (!(on_screen(x0, screen_w) && on_screen(x1, screen_w) &&
                  on_screen(y0, screen_h) && on_screen(y1, screen_h))) begin
                px.rejected = 1'b1;
                expected_pixels.push_back(px);
            end else begin
                cur_x = x0[CB-1:0];
                cur_y = y0[CB-1:0];
                tgt_x = x1[CB-1:0];
                tgt_y = y1[CB-1:0];
                dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
                dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
                dir.x_major = (dx >= dy);
                dir.x_dec   = (x1 < x0);
                dir.y_dec   = (y1 < y0);
                d_major = dir.x_major ? dx : dy;
                d_minor = dir.x_major ? dy : dx;
                err     = 0;
                rgba    = req[4 * CW +: lr_pkg::COLOUR_BITS];
                line_on = 1'b1;
            end
        end else if (line_on) begin
            at_end = dir.x_major ? (cur_x == tgt_x) : (cur_y == tgt_y);
            px.x     = cur_x;
            px.y     = cur_y;
            px.red   = rgba[0 * KW +: KW];
            px.green = rgba[1 * KW +: KW];
            px.blue  = rgba[2 * KW +: KW];
            px.alpha = rgba[3 * KW +: KW];
            px.last  = at_end;
            expected_pixels.push_back(px);
            if (at_end) begin
                line_on = 1'b0;
            end else if (dir.x_major) begin
                cur_x = dir.x_dec ? cur_x - 1'b1 : cur_x + 1'b1;
                err += 2 * d_minor;
                // move the minor axis only once the error is strictly past one half
                if (err > d_major) begin
                    cur_y = dir.y_dec ? cur_y - 1'b1 : cur_y + 1'b1;
                    err -= 2 * d_major;
                end
            end else begin
                cur_y = dir.y_dec ? cur_y - 1'b1 : cur_y + 1'b1;
                err += 2 * d_minor;
                if (err > d_major) begin
                    cur_x = dir.x_dec ? cur_x - 1'b1 : cur_x + 1'b1;
                    err -= 2 * d_major;
                end
            end
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        int     bad;
        if (expected_pixels.size() == 0) begin
            fail_total++;
            $display("%0t ns: result with none expected, actual x %0d y %0d last %0b rejected %0b",
                     $time, i_m_tdata[0 +: CB], i_m_tdata[CB +: CB], i_m_tlast, i_m_tuser);
        end else begin
            want = expected_pixels.pop_front();
            bad  = field_diff("pixel_x", want.x, i_m_tdata[0 +: CB])
                 + field_diff("pixel_y", want.y, i_m_tdata[CB +: CB])
                 + field_diff("red_out", want.red, i_m_tdata[2 * CB +: KW])
                 + field_diff("green_out", want.green, i_m_tdata[2 * CB + KW +: KW])
                 + field_diff("blue_out", want.blue, i_m_tdata[2 * CB + 2 * KW +: KW])
                 + field_diff("alpha_out", want.alpha, i_m_tdata[2 * CB + 3 * KW +: KW])
                 + field_diff("zero fill", 0, i_m_tdata[OUT_W-1:FILL_LSB])
                 + field_diff("last_pixel", want.last, i_m_tlast)
                 + field_diff("rejected", want.rejected, i_m_tuser);
            if (bad != 0)
                fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
            screen_w = lr_pkg::WIDTH_RESET;
            screen_h = lr_pkg::HEIGHT_RESET;
            line_on  = 1'b0;
            cur_x    = '0;
            cur_y    = '0;
            tgt_x    = '0;
            tgt_y    = '0;
            d_major  = 0;
            d_minor  = 0;
            err      = 0;
            dir      = '0;
            rgba     = '0;
        end else begin
            // retire results before predicting this edge's request
            if (i_m_tvalid && i_m_tready)
                check_pixel();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lr_pkg::CFG_IDX_WIDTH: begin
                        screen_w = i_cfg_data;
                    end
                    lr_pkg::CFG_IDX_HEIGHT: begin
                        screen_h = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                rasterize(i_s_tuser, i_s_tdata);
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the line rasterizer testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int IN_W          = lr_pkg::IN_TDATA_BITS;
    localparam int CB            = lr_pkg::COORD_BITS_DEF;
    localparam int OUT_W         = ((2 * CB + lr_pkg::COLOUR_BITS + 7) / 8) * 8;
    localparam int CW            = lr_pkg::IN_COORD_BITS;
    localparam int SCREEN_MAX    = 1 << CB;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 16;
    localparam logic [lr_pkg::CFG_INDEX_BITS-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [lr_pkg::CFG_INDEX_BITS-1:0] CFG_IDX_SPARE_B = 2'd3;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [IN_W-1:0]                   s_tdata   = '0;
    logic                              s_tuser   = lr_pkg::CMD_STEP;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [OUT_W-1:0]                  m_tdata;
    logic                              m_tlast;
    logic                              m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [lr_pkg::CFG_INDEX_BITS-1:0] cfg_index = lr_pkg::CFG_IDX_WIDTH;
    logic [lr_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int pending;
    int fail_count;
    int tx_idle_pct   = 26;
    int rx_idle_pct   = 57;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int view_w        = lr_pkg::WIDTH_RESET;
    int view_h        = lr_pkg::HEIGHT_RESET;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    line_rasterizer #(
        .COORD_BITS (CB)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    line_pixel_checker #(
        .CB    (CB),
        .OUT_W (OUT_W)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Result sink: random stalls, plus a long hold-off whenever one is requested
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int near(input int c, input int span, input int lim);
        int v;
        v = c + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > lim - 1)
            v = lim - 1;
        return v;
    endfunction

    // Keep valid high across back-to-back requests; drop it only for an idle gap
    task automatic send_req(input logic cmd, input logic [IN_W-1:0] payload);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_start(input int x0, input int y0, input int x1, input int y1,
                              input logic [31:0] colour);
        send_req(lr_pkg::CMD_START, {colour, y1[CW-1:0], x1[CW-1:0], y0[CW-1:0], x0[CW-1:0]});
    endtask

    task automatic send_step();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        send_req(lr_pkg::CMD_STEP, noise[IN_W-1:0]);
    endtask

    // Move one coordinate, mostly off screen; the others stay on it where possible
    task automatic send_bad_start(input int lw, input int lh);
        int c[4];
        int slot;
        int lim;
        c[0] = (lw > 0) ? $urandom_range(lw - 1) : $urandom_range(SCREEN_MAX - 1);
        c[1] = (lh > 0) ? $urandom_range(lh - 1) : $urandom_range(SCREEN_MAX - 1);
        c[2] = (lw > 0) ? $urandom_range(lw - 1) : $urandom_range(SCREEN_MAX - 1);
        c[3] = (lh > 0) ? $urandom_range(lh - 1) : $urandom_range(SCREEN_MAX - 1);
        slot = $urandom_range(3);
        lim  = (slot % 2 == 0) ? lw : lh;
        case ($urandom_range(2))
            0: begin
                c[slot] = -int'($urandom_range(SCREEN_MAX, 1));
            end
            1: begin
                c[slot] = (lim < SCREEN_MAX) ? $urandom_range(SCREEN_MAX - 1, lim) : -1;
            end
            default: begin
                c[slot] = $urandom_range(4095);
            end
        endcase
        send_start(c[0], c[1], c[2], c[3], $urandom());
    endtask

    task automatic write_reg(input logic [lr_pkg::CFG_INDEX_BITS-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[lr_pkg::CFG_DATA_BITS-1:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == lr_pkg::CFG_IDX_WIDTH)
            view_w = val;
        else if (idx == lr_pkg::CFG_IDX_HEIGHT)
            view_h = val;
    endtask

    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_screen(input int w, input int h, input bit poke_spare);
        wait_drained(SETTLE_CYCLES);
        write_reg(lr_pkg::CFG_IDX_WIDTH, w);
        write_reg(lr_pkg::CFG_IDX_HEIGHT, h);
        if (poke_spare) begin
            write_reg(CFG_IDX_SPARE_A, $urandom_range(4095));
            write_reg(CFG_IDX_SPARE_B, $urandom_range(4095));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct <= tx;
        rx_idle_pct <= rx;
    endtask

    // Mostly whole lines with random endpoints and colour, some cut short by a new
    // start, some off-screen starts and a few steps past the end of a line.
    task automatic random_phase(input int budget, input int hold_at, input bit pause_mid);
        int sent, lw, lh, x0, y0, x1, y1, dx, dy, span, full, len, n, pick;
        bit held;
        sent = 0;
        held = 1'b0;
        lw   = (view_w < SCREEN_MAX) ? view_w : SCREEN_MAX;
        lh   = (view_h < SCREEN_MAX) ? view_h : SCREEN_MAX;
        while (sent < budget) begin
            if (!held && hold_at >= 0 && sent >= hold_at) begin
                hold_requests <= hold_requests + 1;
                held = 1'b1;
            end
            if (pause_mid && sent >= budget / 2) begin
                pause_mid = 1'b0;
                wait_drained(0);
            end
            pick = $urandom_range(99);
            if (lw == 0 || lh == 0 || pick < 12) begin
                send_bad_start(lw, lh);
                sent++;
            end else begin
                x0   = $urandom_range(lw - 1);
                y0   = $urandom_range(lh - 1);
                pick = $urandom_range(99);
                span = (pick < 70) ? 8 : ((pick < 97) ? 64 : SCREEN_MAX);
                x1   = near(x0, span, lw);
                y1   = near(y0, span, lh);
                send_start(x0, y0, x1, y1, $urandom());
                sent++;
                dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
                dy   = (y1 > y0) ? y1 - y0 : y0 - y1;
                full = ((dx > dy) ? dx : dy) + 1;
                len  = ($urandom_range(99) < 15) ? $urandom_range(full - 1) : full;
                for (n = 0; n < len && sent < budget; n++) begin
                    send_step();
                    sent++;
                end
                // step past the end: the block must stay silent
                if (n == full && $urandom_range(99) < 20)
                    send_step();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // single pixel at the far corner, brightest colour
        send_start(639, 479, 639, 479, 32'hFFFF_FFFF);
        send_step();
        // horizontal, x decreasing, black
        send_start(3, 0, 0, 0, 32'h0000_0000);
        repeat (4) send_step();
        // steep, both axes decreasing, cut short by the next start
        send_start(1, 4, 0, 0, $urandom());
        repeat (3) send_step();
        // vertical, abandoned by the rejected starts below
        send_start(10, 10, 10, 12, $urandom());
        repeat (2) send_step();
        send_start(-2048, 0, 0, 0, $urandom());
        send_start(0, 0, 2047, 0, $urandom());
        send_start(0, 0, 0, 480, $urandom());
        send_start(640, 0, 0, 0, $urandom());
        send_step();
        // shallow, y decreasing, from the bottom edge
        send_start(0, 479, 2, 478, $urandom());
        repeat (3) send_step();

        random_phase(230, -1, 1'b0);
        set_screen(SCREEN_MAX, SCREEN_MAX, 1'b0);
        random_phase(230, 60, 1'b0);

        set_idling(57, 26);
        set_screen(1, 1, 1'b1);
        random_phase(230, -1, 1'b0);
        set_screen(0, SCREEN_MAX, 1'b0);
        random_phase(60, -1, 1'b0);

        set_idling(0, 0);
        set_screen(4095, 1, 1'b0);
        random_phase(230, -1, 1'b1);
        set_screen($urandom_range(SCREEN_MAX, 1), $urandom_range(SCREEN_MAX, 1), 1'b0);
        random_phase(230, -1, 1'b0);

        wait_drained(END_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
